/* rtl/core/pld_pkg.sv */
// Shared codes and field widths for the positional list block.
`default_nettype none
package pld_pkg;
    localparam int unsigned PosW = 7;
    localparam int unsigned ValW = 32;
    localparam int unsigned LenW = 7;
    localparam int unsigned StatW = 2;

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_DELETE = 1'b1;

    localparam logic [StatW-1:0] ST_DONE    = 2'd0;
    localparam logic [StatW-1:0] ST_INVALID = 2'd1;
    localparam logic [StatW-1:0] ST_FULL    = 2'd2;
endpackage
`default_nettype wire

/* rtl/core/positional_list_insert_delete.sv */
// Positional list: ordered store with insert and delete at a 1-based position.
// An insert moves the entries from position p on up by one slot, a delete
// moves those after p down by one; a rejected word makes no move. One
// operation in flight at a time; the single memory port pair and the
// read-then-write move loop set the rate.
// Reset clears the entry count, the state and the output valid flag; list storage is not cleared.
`default_nettype none
module positional_list_insert_delete #(
    parameter int unsigned CAPACITY = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,   // [6:0] position, [38:7] value, [39] zero
    input  wire logic [0:0]  s_axis_tuser,   // [0] kind
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata,   // [31:0] removed_value, [38:32] list_length
    output logic [1:0]       m_axis_tuser    // [1:0] status
);
    localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int unsigned CW = $clog2(CAPACITY + 1);
    localparam int unsigned PW = ((CW > pld_pkg::PosW) ? CW : pld_pkg::PosW) + 1;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_BRD  = 3'd1; // backward move, read
    localparam logic [2:0] S_BWR  = 3'd2; // backward move, write
    localparam logic [2:0] S_INS  = 3'd3;
    localparam logic [2:0] S_DCAP = 3'd4; // capture deleted word
    localparam logic [2:0] S_FRD  = 3'd5; // forward move, read
    localparam logic [2:0] S_FWR  = 3'd6; // forward move, write
    localparam logic [2:0] S_FIN  = 3'd7;

    logic [pld_pkg::ValW-1:0] r_mem [CAPACITY];
    logic [pld_pkg::ValW-1:0] r_rdata;

    logic [2:0]                r_state;
    logic [CW-1:0]             r_count;
    logic [AW-1:0]             r_idx;
    logic [AW-1:0]             r_tgt;
    logic [pld_pkg::ValW-1:0]  r_val;
    logic [pld_pkg::StatW-1:0] r_res_status;
    logic [pld_pkg::ValW-1:0]  r_res_removed;

    logic                      r_out_valid;
    logic [pld_pkg::StatW-1:0] r_out_status;
    logic [pld_pkg::ValW-1:0]  r_out_removed;
    logic [pld_pkg::LenW-1:0]  r_out_len;

    logic                      w_in_acc;
    logic                      w_kind;
    logic [pld_pkg::PosW-1:0]  w_pos;
    logic [pld_pkg::ValW-1:0]  w_value;
    logic [PW-1:0]             w_pos_e;
    logic [PW-1:0]             w_cnt_e;
    logic [PW-1:0]             w_pos_m1;
    logic [PW-1:0]             w_cnt_m1;
    logic                      w_ins_ok;
    logic                      w_full;
    logic                      w_del_ok;
    logic                      w_we;
    logic [AW-1:0]             w_waddr;
    logic [pld_pkg::ValW-1:0]  w_wdata;
    logic [AW-1:0]             w_raddr;
    logic [AW-1:0]             w_idx_dn;
    logic [AW-1:0]             w_idx_up;
    logic                      w_out_load;

    assign w_kind   = s_axis_tuser[0];
    assign w_pos    = s_axis_tdata[pld_pkg::PosW-1:0];
    assign w_value  = s_axis_tdata[pld_pkg::PosW +: pld_pkg::ValW];
    assign w_pos_e  = PW'(w_pos);
    assign w_cnt_e  = PW'(r_count);
    assign w_pos_m1 = w_pos_e - PW'(1);
    assign w_cnt_m1 = w_cnt_e - PW'(1);
    assign w_ins_ok = (w_pos_e != '0) && (w_pos_e <= w_cnt_e + PW'(1));
    assign w_full   = (w_cnt_e == PW'(CAPACITY));
    assign w_del_ok = (w_pos_e != '0) && (w_pos_e <= w_cnt_e);

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_idx_dn      = r_idx - AW'(1);
    assign w_idx_up      = r_idx + AW'(1);
    assign w_out_load    = (r_state == S_FIN) && (!r_out_valid || m_axis_tready);

    // Single shared memory port pair
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_idx;
        w_wdata = r_rdata;
        w_raddr = r_idx;
        case (r_state)
            S_IDLE: begin
                // speculative read of the slot a delete would remove
                w_raddr = w_pos_m1[AW-1:0];
            end
            S_BRD: begin
                w_raddr = w_idx_dn;
            end
            S_BWR: begin
                w_we = 1'b1;
            end
            S_INS: begin
                w_we    = 1'b1;
                w_waddr = r_tgt;
                w_wdata = r_val;
            end
            S_FRD: begin
                w_raddr = w_idx_up;
            end
            S_FWR: begin
                w_we = 1'b1;
            end
            default: begin
                w_raddr = r_idx;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rdata <= r_mem[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        if (w_kind == pld_pkg::KIND_INSERT) begin
                            if (!w_ins_ok || w_full) begin
                                r_state <= S_FIN;
                            end else if (w_pos_e == w_cnt_e + PW'(1)) begin
                                r_state <= S_INS;
                            end else begin
                                r_state <= S_BRD;
                            end
                        end else begin
                            // the read of the deleted word is issued this cycle
                            r_state <= w_del_ok ? S_DCAP : S_FIN;
                        end
                    end
                end
                S_BRD: begin
                    r_state <= S_BWR;
                end
                S_BWR: begin
                    r_state <= (w_idx_dn == r_tgt) ? S_INS : S_BRD;
                end
                S_INS: begin
                    r_count <= r_count + CW'(1);
                    r_state <= S_FIN;
                end
                S_DCAP: begin
                    if (r_idx == r_tgt) begin
                        r_count <= r_count - CW'(1);
                        r_state <= S_FIN;
                    end else begin
                        r_state <= S_FRD;
                    end
                end
                S_FRD: begin
                    r_state <= S_FWR;
                end
                S_FWR: begin
                    if (w_idx_up == r_tgt) begin
                        r_count <= r_count - CW'(1);
                        r_state <= S_FIN;
                    end else begin
                        r_state <= S_FRD;
                    end
                end
                S_FIN: begin
                    if (w_out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Datapath; r_tgt is the insert slot, or the last index for a delete
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    r_val <= w_value;
                    if (w_kind == pld_pkg::KIND_INSERT) begin
                        r_idx         <= w_cnt_e[AW-1:0];
                        r_tgt         <= w_pos_m1[AW-1:0];
                        r_res_removed <= '0;
                        if (!w_ins_ok) begin
                            r_res_status <= pld_pkg::ST_INVALID;
                        end else if (w_full) begin
                            r_res_status <= pld_pkg::ST_FULL;
                        end else begin
                            r_res_status <= pld_pkg::ST_DONE;
                        end
                    end else begin
                        r_idx <= w_pos_m1[AW-1:0];
                        r_tgt <= w_cnt_m1[AW-1:0];
                        if (w_del_ok) begin
                            r_res_status <= pld_pkg::ST_DONE;
                        end else begin
                            r_res_status  <= pld_pkg::ST_INVALID;
                            r_res_removed <= '1;
                        end
                    end
                end
            end
            S_BWR: begin
                r_idx <= w_idx_dn;
            end
            S_DCAP: begin
                r_res_removed <= r_rdata;
            end
            S_FWR: begin
                r_idx <= w_idx_up;
            end
            default: begin
                r_idx <= r_idx;
            end
        endcase
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_status  <= r_res_status;
            r_out_removed <= r_res_removed;
            r_out_len     <= w_cnt_e[pld_pkg::LenW-1:0];
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tdata  = {1'b0, r_out_len, r_out_removed};
endmodule
`default_nettype wire
